### design/ht3d_pkg.sv
package ht3d_pkg;

  localparam logic signed [63:0] MAX64 = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] MIN64 = {1'b1, {63{1'b0}}};

  localparam int CORDIC_STEPS = 20;
  localparam int ANG_W = 28;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q24 = 28'sd26353589;
  localparam logic signed [ANG_W-1:0] CORDIC_GAIN_Q24 = 28'sd10188014;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_SPAN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT = 2'd2;

  typedef struct packed {
    logic signed [ANG_W-1:0] x;
    logic signed [ANG_W-1:0] y;
    logic signed [ANG_W-1:0] ang;
    logic [1:0] quad;
  } cord_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] num;
    logic [63:0] quo;
    logic [63:0] den;
    logic neg;
    logic dz;
  } div_t;

  function automatic logic signed [ANG_W-1:0] atan_q24(input int i);
    logic signed [ANG_W-1:0] r;
    case (i)
      0: r = 28'sd13176795;
      1: r = 28'sd7778716;
      2: r = 28'sd4110060;
      3: r = 28'sd2086331;
      4: r = 28'sd1047214;
      5: r = 28'sd524117;
      6: r = 28'sd262123;
      7: r = 28'sd131069;
      8: r = 28'sd65536;
      9: r = 28'sd32768;
      10: r = 28'sd16384;
      11: r = 28'sd8192;
      12: r = 28'sd4096;
      13: r = 28'sd2048;
      14: r = 28'sd1024;
      15: r = 28'sd512;
      16: r = 28'sd256;
      17: r = 28'sd128;
      18: r = 28'sd64;
      19: r = 28'sd32;
      default: r = '0;
    endcase
    return r;
  endfunction

  // bit 64 is the saturation flag, bits 63:0 the clipped sum
  function automatic logic [64:0] sat_add(input logic signed [63:0] a,
                                          input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return {1'b1, (s[64] ? MIN64 : MAX64)};
    end
    return {1'b0, s[63:0]};
  endfunction

endpackage

### design/ht3d_delay.sv
module ht3d_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] pipe_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      pipe_r[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        pipe_r[i] <= pipe_r[i-1];
      end
    end
  end

  assign q = pipe_r[DEPTH-1];

endmodule

### design/ht3d_mul.sv
module ht3d_mul #(
  parameter int SHIFT = 16
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output logic signed [63:0] p,
  output logic               ovf
);
  import ht3d_pkg::*;

  logic signed [32:0] a0, a1, b0, b1;
  logic signed [65:0] pp00_r, pp01_r, pp10_r, pp11_r;
  logic signed [127:0] prod_r;
  logic signed [127:0] sh;
  logic fits;

  assign a0 = $signed({1'b0, a[31:0]});
  assign b0 = $signed({1'b0, b[31:0]});
  assign a1 = 33'($signed(a[63:32]));
  assign b1 = 33'($signed(b[63:32]));

  assign sh = prod_r >>> SHIFT;
  assign fits = (&sh[127:63]) | ~(|sh[127:63]);

  always_ff @(posedge clk) begin
    if (en) begin
      pp00_r <= a0 * b0;
      pp01_r <= a0 * b1;
      pp10_r <= a1 * b0;
      pp11_r <= a1 * b1;
      prod_r <= (128'(pp11_r) <<< 64) + ((128'(pp01_r) + 128'(pp10_r)) <<< 32)
                + 128'(pp00_r);
      p      <= fits ? sh[63:0] : (sh[127] ? MIN64 : MAX64);
      ovf    <= ~fits;
    end
  end

endmodule

### design/ht3d_cordic_cell.sv
module ht3d_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic            clk,
  input  logic            en,
  input  ht3d_pkg::cord_t d,
  output ht3d_pkg::cord_t q
);
  import ht3d_pkg::*;

  localparam logic signed [ANG_W-1:0] ATAN = atan_q24(STEP);

  logic signed [ANG_W-1:0] xs, ys;

  assign xs = $signed(d.x) >>> STEP;
  assign ys = $signed(d.y) >>> STEP;

  always_ff @(posedge clk) begin
    if (en) begin
      if (!d.ang[ANG_W-1]) begin
        q.x   <= d.x - ys;
        q.y   <= d.y + xs;
        q.ang <= d.ang - ATAN;
      end else begin
        q.x   <= d.x + ys;
        q.y   <= d.y - xs;
        q.ang <= d.ang + ATAN;
      end
      q.quad <= d.quad;
    end
  end

endmodule

### design/ht3d_div_cell.sv
module ht3d_div_cell (
  input  logic           clk,
  input  logic           en,
  input  ht3d_pkg::div_t d,
  output ht3d_pkg::div_t q
);
  import ht3d_pkg::*;

  logic [64:0] trial;
  logic [64:0] diff;
  logic ge;

  assign trial = {d.rem, d.num[63]};
  assign diff  = trial - {1'b0, d.den};
  assign ge    = trial >= {1'b0, d.den};

  always_ff @(posedge clk) begin
    if (en) begin
      q.rem <= ge ? diff[63:0] : trial[63:0];
      q.num <= {d.num[62:0], 1'b0};
      q.quo <= {d.quo[62:0], ge};
      q.den <= d.den;
      q.neg <= d.neg;
      q.dz  <= d.dz;
    end
  end

endmodule

### design/hypertile_3d_point_transform.sv
// Hyperbolic tiling transform of 3D points: one per clock unless stalled.
// Input channel (in_valid/in_ready): point x/y/z in signed fixed point with
// FRAC_BITS fraction bits and a Q0.16 random fraction that picks the
// rotation angle. Result channel (out_valid/out_ready): the weighted x/y/z
// increments and an overflow flag for any divide-by-zero or saturation.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0
// center offset, 1 angle span, 2 weight; other indexes are ignored. cfg_ready
// is always high. Write only while no item is in flight.
// Throughput: one item per cycle while the output is not stalled. The depth
// is set by the 64-cell restoring divider chain for weight/den, with the
// 3-stage multipliers and the 20-cell sin/cos chain around it.
// Reset: synchronous, active low; clears all valid bits and loads the
// register defaults. The derived c2_r, s2x_r, s2y_r and wsh_r are registered.
// Stall: when out_ready is low and a result waits, the pipeline still moves
// while its last stage is empty; once the last stage holds an item the whole
// pipeline holds and in_ready drops.
module hypertile_3d_point_transform #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_point_x,
  input  logic signed [COORD_WIDTH-1:0] in_point_y,
  input  logic signed [COORD_WIDTH-1:0] in_point_z,
  input  logic [15:0]                   in_rand_fraction,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] out_delta_x,
  output logic signed [COORD_WIDTH-1:0] out_delta_y,
  output logic signed [COORD_WIDTH-1:0] out_delta_z,
  output logic                          out_overflow,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ht3d_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);
  import ht3d_pkg::*;

  localparam int VS = FRAC_BITS + 16;
  localparam int UP = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int DN = (FRAC_BITS >= 16) ? 0 : 16 - FRAC_BITS;
  localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;
  localparam int LAST = 81;

  function automatic logic [COORD_WIDTH:0] clamp(input logic [63:0] v);
    logic fit;
    fit = (&v[63:COORD_WIDTH-1]) | ~(|v[63:COORD_WIDTH-1]);
    if (fit) return {1'b0, v[COORD_WIDTH-1:0]};
    return {1'b1, v[63], {(COORD_WIDTH-1){~v[63]}}};
  endfunction

  // configuration and derived constants
  logic [16:0] center_r;
  logic [17:0] span_r;
  logic [31:0] weight_r;
  logic signed [63:0] cx, c2x, c2_r, s2x_r, s2y_r, wsh_r;
  logic [63:0] cxsq;
  logic signed [127:0] wwide;
  logic wf_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r <= 17'd65536;
      span_r   <= 18'd89872;
      weight_r <= 32'd65536;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CENTER_OFFSET: center_r <= cfg_data[16:0];
        REG_ANGLE_SPAN:    span_r   <= cfg_data[17:0];
        REG_WEIGHT:        weight_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cx    = $signed((64'(center_r) << UP) >> DN);
  assign c2x   = cx <<< 1;
  assign cxsq  = 64'(cx[31:0]) * 64'(cx[31:0]);
  assign wwide = 128'($signed(weight_r)) <<< VS;

  always_ff @(posedge clk) begin
    c2_r  <= $signed(cxsq >> FRAC_BITS);
    s2x_r <= ONE + c2_r;
    s2y_r <= ONE - c2_r;
    if ((&wwide[127:63]) | ~(|wwide[127:63])) begin
      wsh_r <= wwide[63:0];
      wf_r  <= 1'b0;
    end else begin
      wsh_r <= wwide[127] ? MIN64 : MAX64;
      wf_r  <= 1'b1;
    end
  end

  // pipeline control
  logic en;
  logic [LAST-1:0] vld_r;
  logic out_valid_r;

  assign en = !(out_valid_r && !out_ready && vld_r[LAST-1]);
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAST-2:0], in_valid};
    end
  end

  // first multiply level
  logic signed [63:0] px, py, pz;
  logic signed [63:0] m_sqx, m_sqy, m_sqz, m_xs, m_yn, m_zn, m_cx2;
  logic [6:0] m1_ovf;

  assign px = 64'(in_point_x);
  assign py = 64'(in_point_y);
  assign pz = 64'(in_point_z);

  ht3d_mul #(.SHIFT(FRAC_BITS)) u_m_sqx (.clk, .en, .a(px), .b(px), .p(m_sqx), .ovf(m1_ovf[0]));
  ht3d_mul #(.SHIFT(FRAC_BITS)) u_m_sqy (.clk, .en, .a(py), .b(py), .p(m_sqy), .ovf(m1_ovf[1]));
  ht3d_mul #(.SHIFT(FRAC_BITS)) u_m_sqz (.clk, .en, .a(pz), .b(pz), .p(m_sqz), .ovf(m1_ovf[2]));
  ht3d_mul #(.SHIFT(FRAC_BITS)) u_m_xs (.clk, .en, .a(px), .b(s2x_r), .p(m_xs),
                                        .ovf(m1_ovf[3]));
  ht3d_mul #(.SHIFT(FRAC_BITS)) u_m_yn (.clk, .en, .a(py), .b(s2y_r), .p(m_yn),
                                        .ovf(m1_ovf[4]));
  ht3d_mul #(.SHIFT(FRAC_BITS)) u_m_zn (.clk, .en, .a(pz), .b(s2y_r), .p(m_zn),
                                        .ovf(m1_ovf[5]));
  ht3d_mul #(.SHIFT(FRAC_BITS)) u_m_cx2 (.clk, .en, .a(c2x), .b(px), .p(m_cx2),
                                         .ovf(m1_ovf[6]));

  // squared radius
  logic [64:0] s_r2a, s_r2, s_r2p1;
  logic signed [63:0] r2a_r, sqz_r, r2_r, r2p1_r, r2b_r;
  logic f4_r, f5_r, f6_r;

  assign s_r2a  = sat_add(m_sqx, m_sqy);
  assign s_r2   = sat_add(r2a_r, sqz_r);
  assign s_r2p1 = sat_add(r2_r, ONE);

  always_ff @(posedge clk) begin
    if (en) begin
      r2a_r  <= s_r2a[63:0];
      sqz_r  <= m_sqz;
      f4_r   <= (|m1_ovf) | s_r2a[64];
      r2_r   <= s_r2[63:0];
      f5_r   <= f4_r | s_r2[64];
      r2p1_r <= s_r2p1[63:0];
      r2b_r  <= r2_r;
      f6_r   <= f5_r | s_r2p1[64];
    end
  end

  // second multiply level
  logic signed [63:0] m_cr, m_cd, d_xs, d_cx2;
  logic [1:0] m2_ovf;
  logic f9;

  ht3d_mul #(.SHIFT(FRAC_BITS)) u_m_cr (.clk, .en, .a(cx), .b(r2p1_r), .p(m_cr),
                                        .ovf(m2_ovf[0]));
  ht3d_mul #(.SHIFT(FRAC_BITS)) u_m_cd (.clk, .en, .a(c2_r), .b(r2b_r), .p(m_cd),
                                        .ovf(m2_ovf[1]));
  ht3d_delay #(.WIDTH(64), .DEPTH(6)) u_d_xs (.clk, .en, .d(m_xs), .q(d_xs));
  ht3d_delay #(.WIDTH(64), .DEPTH(6)) u_d_cx2 (.clk, .en, .d(m_cx2), .q(d_cx2));
  ht3d_delay #(.WIDTH(1), .DEPTH(3)) u_d_f6 (.clk, .en, .d(f6_r), .q(f9));

  // numerator x and divisor
  logic [64:0] s_xn, s_den0, s_den;
  logic signed [63:0] xn_r, den0_r, den_r, xn2_r;
  logic f10_r, f11_r;

  assign s_xn   = sat_add(d_xs, m_cr);
  assign s_den0 = sat_add(m_cd, d_cx2);
  assign s_den  = sat_add(den0_r, ONE);

  always_ff @(posedge clk) begin
    if (en) begin
      xn_r   <= s_xn[63:0];
      den0_r <= s_den0[63:0];
      f10_r  <= f9 | (|m2_ovf) | s_xn[64] | s_den0[64];
      den_r  <= s_den[63:0];
      xn2_r  <= xn_r;
      f11_r  <= f10_r | s_den[64];
    end
  end

  // divider chain: vr = wsh / den, truncated toward zero
  div_t div_s [65];
  logic signed [63:0] vr_r;
  logic df_r;
  logic [63:0] q_mag;

  always_ff @(posedge clk) begin
    if (en) begin
      div_s[0].rem <= '0;
      div_s[0].num <= wsh_r[63] ? (64'd0 - wsh_r) : wsh_r;
      div_s[0].quo <= '0;
      div_s[0].den <= den_r[63] ? (64'd0 - den_r) : den_r;
      div_s[0].neg <= wsh_r[63] ^ den_r[63];
      div_s[0].dz  <= (den_r == '0);
    end
  end

  for (genvar i = 0; i < 64; i++) begin : g_div
    ht3d_div_cell u_cell (.clk, .en, .d(div_s[i]), .q(div_s[i+1]));
  end

  assign q_mag = div_s[64].quo;

  always_ff @(posedge clk) begin
    if (en) begin
      if (div_s[64].dz) begin
        vr_r <= (wsh_r == '0) ? '0 : (wsh_r[63] ? MIN64 : MAX64);
        df_r <= 1'b1;
      end else if (div_s[64].neg) begin
        vr_r <= $signed(64'd0 - q_mag);
        df_r <= 1'b0;
      end else if (q_mag[63]) begin
        vr_r <= MAX64;
        df_r <= 1'b1;
      end else begin
        vr_r <= $signed(q_mag);
        df_r <= 1'b0;
      end
    end
  end

  // rotation angle and sin/cos chain
  logic [33:0] ang_prod;
  logic [25:0] ang_r;
  logic signed [ANG_W-1:0] red_ang;
  logic [1:0] red_quad;
  cord_t cord_s [CORDIC_STEPS+1];
  logic signed [63:0] cs_r, sn_r;

  assign ang_prod = 34'(in_rand_fraction) * 34'(span_r);

  always_comb begin
    red_ang  = $signed({2'b00, ang_r});
    red_quad = '0;
    for (int i = 0; i < 3; i++) begin
      if (red_ang > HALF_PI_Q24) begin
        red_ang  = red_ang - HALF_PI_Q24;
        red_quad = red_quad + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang_r            <= ang_prod[33:8];
      cord_s[0].x      <= CORDIC_GAIN_Q24;
      cord_s[0].y      <= '0;
      cord_s[0].ang    <= red_ang;
      cord_s[0].quad   <= red_quad;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    ht3d_cordic_cell #(.STEP(i)) u_cell (.clk, .en, .d(cord_s[i]), .q(cord_s[i+1]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      case (cord_s[CORDIC_STEPS].quad)
        2'd0: begin
          cs_r <= 64'(cord_s[CORDIC_STEPS].x);
          sn_r <= 64'(cord_s[CORDIC_STEPS].y);
        end
        2'd1: begin
          cs_r <= -64'(cord_s[CORDIC_STEPS].y);
          sn_r <= 64'(cord_s[CORDIC_STEPS].x);
        end
        2'd2: begin
          cs_r <= -64'(cord_s[CORDIC_STEPS].x);
          sn_r <= -64'(cord_s[CORDIC_STEPS].y);
        end
        default: begin
          cs_r <= 64'(cord_s[CORDIC_STEPS].y);
          sn_r <= -64'(cord_s[CORDIC_STEPS].x);
        end
      endcase
    end
  end

  // align xn, yn, sin/cos, zn and the overflow flag for rotation and weighting
  logic signed [63:0] xn_d, yn_d, cs_d, sn_d, zn_d;
  logic f81_path, df81, f81_rot;

  ht3d_delay #(.WIDTH(64), .DEPTH(63)) u_d_xn (.clk, .en, .d(xn2_r), .q(xn_d));
  ht3d_delay #(.WIDTH(64), .DEPTH(71)) u_d_yn (.clk, .en, .d(m_yn), .q(yn_d));
  ht3d_delay #(.WIDTH(128), .DEPTH(51)) u_d_sc (.clk, .en, .d({cs_r, sn_r}),
                                               .q({cs_d, sn_d}));
  ht3d_delay #(.WIDTH(64), .DEPTH(75)) u_d_zn (.clk, .en, .d(m_zn), .q(zn_d));
  ht3d_delay #(.WIDTH(1), .DEPTH(70)) u_d_f11 (.clk, .en, .d(f11_r), .q(f81_path));

  // rotation
  logic signed [63:0] p_xc, p_ys, p_yc, p_xs;
  logic [3:0] m4_ovf;
  logic [64:0] s_t1, s_t2;
  logic signed [63:0] t1_r, t2_r, vr2_r;
  logic f78_r, df2_r;

  ht3d_mul #(.SHIFT(24)) u_m_xc (.clk, .en, .a(xn_d), .b(cs_d), .p(p_xc), .ovf(m4_ovf[0]));
  ht3d_mul #(.SHIFT(24)) u_m_ys (.clk, .en, .a(yn_d), .b(sn_d), .p(p_ys), .ovf(m4_ovf[1]));
  ht3d_mul #(.SHIFT(24)) u_m_yc (.clk, .en, .a(yn_d), .b(cs_d), .p(p_yc), .ovf(m4_ovf[2]));
  ht3d_mul #(.SHIFT(24)) u_m_xsn (.clk, .en, .a(xn_d), .b(sn_d), .p(p_xs), .ovf(m4_ovf[3]));

  assign s_t1 = sat_add(p_xc, p_ys);
  assign s_t2 = sat_add(p_yc, 64'd0 - p_xs);

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r  <= s_t1[63:0];
      t2_r  <= s_t2[63:0];
      f78_r <= (|m4_ovf) | s_t1[64] | s_t2[64];
      vr2_r <= vr_r;
      df2_r <= df_r;
    end
  end

  ht3d_delay #(.WIDTH(1), .DEPTH(3)) u_d_df (.clk, .en, .d(df2_r), .q(df81));
  ht3d_delay #(.WIDTH(1), .DEPTH(3)) u_d_f78 (.clk, .en, .d(f78_r), .q(f81_rot));

  // weighting
  logic signed [63:0] q_x, q_y, q_z;
  logic [2:0] m5_ovf;
  logic [COORD_WIDTH:0] c_x, c_y, c_z;

  ht3d_mul #(.SHIFT(VS)) u_m_dx (.clk, .en, .a(vr2_r), .b(t1_r), .p(q_x), .ovf(m5_ovf[0]));
  ht3d_mul #(.SHIFT(VS)) u_m_dy (.clk, .en, .a(vr2_r), .b(t2_r), .p(q_y), .ovf(m5_ovf[1]));
  ht3d_mul #(.SHIFT(VS)) u_m_dz (.clk, .en, .a(vr2_r), .b(zn_d), .p(q_z), .ovf(m5_ovf[2]));

  assign c_x = clamp(q_x);
  assign c_y = clamp(q_y);
  assign c_z = clamp(q_z);

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en && vld_r[LAST-1]) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && vld_r[LAST-1]) begin
      out_delta_x  <= c_x[COORD_WIDTH-1:0];
      out_delta_y  <= c_y[COORD_WIDTH-1:0];
      out_delta_z  <= c_z[COORD_WIDTH-1:0];
      out_overflow <= f81_path | df81 | f81_rot | (|m5_ovf) | c_x[COORD_WIDTH]
                      | c_y[COORD_WIDTH] | c_z[COORD_WIDTH] | wf_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### design/ht3d_chk.sv
module ht3d_chk #(
  parameter int COORD_WIDTH = 32
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [COORD_WIDTH-1:0] out_delta_x,
  input logic [COORD_WIDTH-1:0] out_delta_y,
  input logic [COORD_WIDTH-1:0] out_delta_z,
  input logic                   out_overflow,
  input logic                   cfg_valid,
  input logic                   cfg_ready
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n) cfg_valid |-> cfg_ready)
    else $error("config write refused");

  a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_delta_x) && $stable(out_delta_y)
      && $stable(out_delta_z) && $stable(out_overflow))
    else $error("result changed while stalled");

endmodule

bind hypertile_3d_point_transform ht3d_chk #(.COORD_WIDTH(COORD_WIDTH)) u_ht3d_chk (.*);

### tb/sv/hypertile_3d_point_transform_checker.sv
module hypertile_3d_point_transform_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic signed [31:0]             in_point_x,
  input  logic signed [31:0]             in_point_y,
  input  logic signed [31:0]             in_point_z,
  input  logic [15:0]                    in_rand_fraction,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic signed [31:0]             out_delta_x,
  input  logic signed [31:0]             out_delta_y,
  input  logic signed [31:0]             out_delta_z,
  input  logic                           out_overflow,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [ht3d_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  output int                             fail_count,
  output int                             pending_count,
  output int                             result_count,
  output int                             overflow_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import ht3d_pkg::*;

  localparam int FB = 16;
  localparam int VS = 32;
  localparam logic signed [63:0] ONE = 64'sd65536;

  typedef struct packed {
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] dz;
    logic               ovf;
  } delta_t;

  logic [16:0]        center_offset;
  logic [17:0]        angle_span;
  logic signed [31:0] weight;
  delta_t             delta_q[$];

  function automatic logic signed [63:0] mul_floor(input logic signed [63:0] a,
                                                   input logic signed [63:0] b,
                                                   input int s, ref bit f);
    logic signed [127:0] p;
    p = a * b;
    p = p >>> s;
    if (p > 128'sh7fffffffffffffff) begin
      f = 1;
      return MAX64;
    end
    if (p < -128'sh8000000000000000) begin
      f = 1;
      return MIN64;
    end
    return p[63:0];
  endfunction

  function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                 input logic signed [63:0] b,
                                                 ref bit f);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      f = 1;
      return s[64] ? MIN64 : MAX64;
    end
    return s[63:0];
  endfunction

  function automatic logic signed [31:0] clip32(input logic signed [63:0] v, ref bit f);
    if (v > 64'sd2147483647) begin
      f = 1;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      f = 1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic void rotate_sincos(input logic signed [63:0] a_in,
                                        output logic signed [63:0] sn,
                                        output logic signed [63:0] cs);
    logic signed [63:0] a, x, y, t;
    int quad;
    a = a_in;
    quad = 0;
    x = CORDIC_GAIN_Q24;
    y = 0;
    for (int i = 0; i < 3; i++) begin
      if (a > HALF_PI_Q24) begin
        a -= HALF_PI_Q24;
        quad++;
      end
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (a >= 0) begin
        t = x - (y >>> i); y = y + (x >>> i); x = t; a -= atan_q24(i);
      end else begin
        t = x + (y >>> i); y = y - (x >>> i); x = t; a += atan_q24(i);
      end
    end
    case (quad)
      0: begin cs = x; sn = y; end
      1: begin cs = -y; sn = x; end
      2: begin cs = -x; sn = -y; end
      default: begin cs = y; sn = -x; end
    endcase
  endfunction

  function automatic delta_t predict_delta(input logic signed [31:0] px,
                                           input logic signed [31:0] py,
                                           input logic signed [31:0] pz,
                                           input logic [15:0] rnd);
    bit f;
    logic signed [63:0] cx, c2, s2x, s2y, r2, xn, yn, zn, den, vr, sn, cs, t1, t2, num, ang;
    delta_t d;
    f = 0;
    cx = {47'd0, center_offset};
    c2 = mul_floor(cx, cx, FB, f);
    s2x = ONE + c2;
    s2y = ONE - c2;
    r2 = add_sat(mul_floor(px, px, FB, f), mul_floor(py, py, FB, f), f);
    r2 = add_sat(r2, mul_floor(pz, pz, FB, f), f);
    xn = add_sat(mul_floor(px, s2x, FB, f),
                 mul_floor(cx, add_sat(r2, ONE, f), FB, f), f);
    yn = mul_floor(py, s2y, FB, f);
    zn = mul_floor(pz, s2y, FB, f);
    den = add_sat(mul_floor(c2, r2, FB, f), mul_floor(2 * cx, px, FB, f), f);
    den = add_sat(den, ONE, f);
    num = 64'(weight) <<< VS;
    if (den == 0) begin
      f = 1;
      vr = (num == 0) ? 64'sd0 : (num > 0 ? MAX64 : MIN64);
    end else if (num == MIN64 && den == -1) begin
      f = 1;
      vr = MAX64;
    end else begin
      vr = num / den;
    end
    ang = ({48'd0, rnd} * {46'd0, angle_span}) >> 8;
    rotate_sincos(ang, sn, cs);
    t1 = add_sat(mul_floor(xn, cs, 24, f), mul_floor(yn, sn, 24, f), f);
    t2 = add_sat(mul_floor(yn, cs, 24, f), -mul_floor(xn, sn, 24, f), f);
    d.dx = clip32(mul_floor(vr, t1, VS, f), f);
    d.dy = clip32(mul_floor(vr, t2, VS, f), f);
    d.dz = clip32(mul_floor(vr, zn, VS, f), f);
    d.ovf = f;
    return d;
  endfunction

  assign pending_count = delta_q.size();

  always @(posedge clk) begin
    delta_t got, want;
    if (!rst_n) begin
      center_offset <= 17'd65536;
      angle_span <= 18'd89872;
      weight <= 32'sd65536;
      delta_q.delete();
      fail_count <= 0;
      result_count <= 0;
      overflow_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CENTER_OFFSET: center_offset <= cfg_data[16:0];
          REG_ANGLE_SPAN: angle_span <= cfg_data[17:0];
          REG_WEIGHT: weight <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        delta_q.push_back(predict_delta(in_point_x, in_point_y, in_point_z, in_rand_fraction));
      if (out_valid && out_ready) begin
        got = '{out_delta_x, out_delta_y, out_delta_z, out_overflow};
        result_count <= result_count + 1;
        if (delta_q.size() == 0) begin
          $error("result with no item pending: dx=%0d dy=%0d dz=%0d", got.dx, got.dy, got.dz);
          fail_count <= fail_count + 1;
        end else begin
          want = delta_q.pop_front();
          if (want.ovf) overflow_count <= overflow_count + 1;
          if (got != want) begin
            fail_count <= fail_count + 1;
            if (got.dx != want.dx) $error("delta_x expected %0d got %0d", want.dx, got.dx);
            if (got.dy != want.dy) $error("delta_y expected %0d got %0d", want.dy, got.dy);
            if (got.dz != want.dz) $error("delta_z expected %0d got %0d", want.dz, got.dz);
            if (got.ovf != want.ovf)
              $error("overflow expected %0d got %0d", want.ovf, got.ovf);
          end
        end
      end
    end
  end
endmodule

### tb/sv/hypertile_3d_point_transform_tb.sv
module hypertile_3d_point_transform_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ht3d_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 100;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready, out_overflow;
  logic signed [31:0] in_point_x, in_point_y, in_point_z;
  logic signed [31:0] out_delta_x, out_delta_y, out_delta_z;
  logic [15:0] in_rand_fraction;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;
  int fail_count, pending_count, result_count, overflow_count;
  int idle_cycles;
  bit quiet;

  hypertile_3d_point_transform dut (.*);
  hypertile_3d_point_transform_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // sink side: random stall bursts until the quiet tail
  initial begin
    out_ready = 0;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      out_ready <= 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_valid)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  task automatic send_point(input logic signed [31:0] x, input logic signed [31:0] y,
                            input logic signed [31:0] z, input logic [15:0] r);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1;
    in_point_x <= x;
    in_point_y <= y;
    in_point_z <= z;
    in_rand_fraction <= r;
    do @(posedge clk); while (!in_ready);
  endtask

  // wait out every pending result and the pipeline depth before touching registers
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $signed($urandom_range(0, 2097152)) - 32'sd1048576;
      2: return $signed($urandom_range(0, 16384)) - 32'sd8192;
      3: return -32'sd65536 + $signed($urandom_range(0, 64)) - 32'sd32;
      default: return $signed($urandom_range(0, 524288)) - 32'sd262144;
    endcase
  endfunction

  task automatic random_points(input int n);
    for (int i = 0; i < n; i++)
      send_point(pick_coord(), pick_coord(), pick_coord(), 16'($urandom));
  endtask

  initial begin
    logic [16:0] centers[5] = '{17'd0, 17'd65536, 17'd32768, 17'd1, 17'd0};
    logic [17:0] spans[5] = '{18'd0, 18'd137258, 18'd262143, 18'd65536, 18'd0};
    logic [31:0] weights[5] = '{32'h80000000, 32'h7fffffff, 32'd0, 32'hffff0000, 32'd0};
    rst_n = 0;
    quiet = 0;
    in_valid = 0;
    in_point_x = 0;
    in_point_y = 0;
    in_point_z = 0;
    in_rand_fraction = 0;
    cfg_valid = 0;
    cfg_index = REG_CENTER_OFFSET;
    cfg_data = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // reset defaults: extremes, the zero divisor at (-1,0,0), saturating points
    send_point(0, 0, 0, 0);
    send_point(-32'sd65536, 0, 0, 16'hffff);
    send_point(-32'sd65536, 0, 0, 0);
    send_point(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 16'hffff);
    send_point(32'sh80000000, 32'sh80000000, 32'sh80000000, 0);
    send_point(32'sh7fffffff, 32'sh80000000, 0, 16'h8000);
    send_point(32'sd65536, 32'sd65536, 32'sd65536, 16'h4000);
    send_point(32'sd1, -32'sd1, 32'sd1, 16'h0001);
    send_point(-32'sd1, 32'sd1, -32'sd1, 16'hc000);
    send_point(32'sh55555555, 32'shaaaaaaaa, 32'sh55555555, 16'haaaa);
    send_point(32'shaaaaaaaa, 32'sh55555555, 32'shaaaaaaaa, 16'h5555);
    random_points(160);

    for (int p = 0; p < 6; p++) begin
      drain();
      if (p < 5) begin
        write_reg(REG_CENTER_OFFSET, 32'(centers[p]));
        write_reg(REG_ANGLE_SPAN, 32'(spans[p]));
        write_reg(REG_WEIGHT, weights[p]);
      end else begin
        write_reg(REG_CENTER_OFFSET, $urandom_range(0, 65536));
        write_reg(REG_ANGLE_SPAN, $urandom_range(0, 137258));
        write_reg(REG_WEIGHT, $urandom);
        quiet = 1;
      end
      write_reg(2'd3, $urandom);
      repeat (4) @(posedge clk);
      send_point(-32'sd65536, 0, 0, 16'hffff);
      send_point(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 0);
      random_points(p == 5 ? 260 : 200);
    end

    in_valid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d points over 7 register settings, %0d of them flagged overflow",
             result_count, overflow_count);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end
endmodule

### filelist.f
design/ht3d_pkg.sv
design/ht3d_delay.sv
design/ht3d_mul.sv
design/ht3d_cordic_cell.sv
design/ht3d_div_cell.sv
design/hypertile_3d_point_transform.sv
design/ht3d_chk.sv
tb/sv/hypertile_3d_point_transform_checker.sv
tb/sv/hypertile_3d_point_transform_tb.sv
